/* src/assert_macros.svh */
// assertion macros for the segment tree sources
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, quiet while reset is low
`define SEGT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("segment tree assertion failed");
// clocked check that also holds through reset
`define SEGT_ASSERT_NRST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("segment tree assertion failed during reset");
`else
`define SEGT_ASSERT(lbl, prop)
`define SEGT_ASSERT_NRST(lbl, prop)
`endif

`endif

/* src/segt_pkg.sv */
// shared constants and types of the segment tree range sum block
package segt_pkg;

  // default tree size and element width
  localparam int ELEMENT_COUNT_DEF = 1024;
  localparam int VALUE_BITS_DEF    = 32;

  // fixed port field widths
  localparam int POS_W = 10;
  localparam int NV_W  = 32;
  localparam int OUT_W = 48;

  // request kinds
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // operation of the shared sum unit
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

endpackage

/* src/segt_alu.sv */
// shared add/subtract unit for node sums and the query accumulator
module segt_alu #(
  parameter int W = 42
) (
  input  logic              [W-1:0] a_i,
  input  logic              [W-1:0] b_i,
  input  segt_pkg::alu_op_e         op_i,
  output logic              [W-1:0] y_o
);

  // modulo 2^W add or subtract
  always_comb begin
    case (op_i)
      segt_pkg::ALU_ADD: y_o = a_i + b_i;
      segt_pkg::ALU_SUB: y_o = a_i - b_i;
      default:           y_o = a_i + b_i;
    endcase
  end

endmodule

/* src/segt_node_mem.sv */
// node sum memory with a clearing sweep after reset
module segt_node_mem #(
  parameter int DEPTH  = 2047,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 42
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              busy_o
);

  logic [DATA_W-1:0] node_mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [ADDR_W-1:0] clr_q;
  logic              busy_q;

  // clear sweep counter, one entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      if (clr_q == ADDR_W'(DEPTH - 1)) begin
        busy_q <= 1'b0;
      end else begin
        clr_q <= clr_q + ADDR_W'(1);
      end
    end
  end

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      node_mem_q[clr_q] <= '0;
    end else if (we_i) begin
      node_mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= node_mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

/* src/segment_tree_range_sum.sv */
// segment tree range sum, top level: sequencer, node memory and shared adder.
// The block keeps a segment tree of partial sums over ELEMENT_COUNT signed
// elements, all zero after reset. A point update (cmd 0) walks from the root
// down to the leaf one level at a time, writes the leaf, then climbs back
// level by level (sibling read, then add and parent write), and gives no
// result. A range query (cmd 1) forms the sum as prefix(last+1) -
// prefix(first) with two prefix walks down from the root, at most one node
// read per level overlapped with the accumulate. The memory has a single
// read port and the adder is shared; the block takes one request at a time.
// After reset a clearing sweep writes every tree node (2*ELEMENT_COUNT-1 for
// a power-of-two size, 2047 at the default, 4*ELEMENT_COUNT otherwise), and no
// request is taken until it ends. A result waits in an output register, so
// the next request can start while it is unread.
`include "assert_macros.svh"

module segment_tree_range_sum #(
  parameter int ELEMENT_COUNT = segt_pkg::ELEMENT_COUNT_DEF,
  parameter int VALUE_BITS    = segt_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 cmd_i,
  input  logic        [segt_pkg::POS_W-1:0]    position_i,
  input  logic signed [segt_pkg::NV_W-1:0]     new_value_i,
  input  logic        [segt_pkg::POS_W-1:0]    range_first_i,
  input  logic        [segt_pkg::POS_W-1:0]    range_last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [segt_pkg::OUT_W-1:0]    range_sum_o
);

  localparam int IDX_W      = $clog2(ELEMENT_COUNT);
  localparam int X_W        = IDX_W + 1;
  localparam int NODE_DEPTH = ((ELEMENT_COUNT & (ELEMENT_COUNT - 1)) == 0)
                              ? 2 * ELEMENT_COUNT - 1 : 4 * ELEMENT_COUNT;
  localparam int NODE_W     = $clog2(NODE_DEPTH);
  localparam int SUM_W      = (VALUE_BITS + IDX_W > segt_pkg::OUT_W)
                              ? segt_pkg::OUT_W : VALUE_BITS + IDX_W;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_UDESC  = 8'b0000_0010,
    ST_UREAD  = 8'b0000_0100,
    ST_UADD   = 8'b0000_1000,
    ST_QSTART = 8'b0001_0000,
    ST_QDESC  = 8'b0010_0000,
    ST_QDRAIN = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_e;

  state_e                           state_q, state_d;
  logic              [NODE_W-1:0]   node_q, node_d;
  logic              [IDX_W-1:0]    s_q, s_d;
  logic              [IDX_W-1:0]    e_q, e_d;
  logic              [X_W-1:0]      x_q, x_d;
  logic              [X_W-1:0]      xl_q, xl_d;
  logic                             phase_q, phase_d;
  logic                             pend_q, pend_d;
  segt_pkg::alu_op_e                sub_q, sub_d;
  logic              [SUM_W-1:0]    acc_q, acc_d;
  logic                             out_valid_q, out_valid_d;
  logic signed [segt_pkg::OUT_W-1:0] out_sum_q, out_sum_d;

  logic              [IDX_W-1:0]    mid;
  logic              [X_W-1:0]      mid_x;
  logic              [X_W-1:0]      mid_p1;
  logic              [NODE_W-1:0]   lchild;
  logic              [NODE_W-1:0]   rchild;
  logic              [NODE_W-1:0]   sibling;
  logic              [NODE_W-1:0]   parent;
  logic              [segt_pkg::OUT_W-1:0] nv_ext;
  logic              [VALUE_BITS-1:0] nv_wrap;
  logic              [SUM_W-1:0]    leaf_val;
  logic                             pos_ok;
  logic                             q_ok;
  logic              [31:0]         hi_p1;
  logic              [X_W-1:0]      xh;
  logic                             accept;
  segt_pkg::alu_op_e                phase_op;

  logic                             mem_we;
  logic              [NODE_W-1:0]   mem_waddr;
  logic              [SUM_W-1:0]    mem_wdata;
  logic              [NODE_W-1:0]   mem_raddr;
  logic              [SUM_W-1:0]    mem_rdata;
  logic                             clr_busy;
  logic              [SUM_W-1:0]    alu_y;

  segt_node_mem #(
    .DEPTH  (NODE_DEPTH),
    .ADDR_W (NODE_W),
    .DATA_W (SUM_W)
  ) u_node_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .busy_o  (clr_busy)
  );

  segt_alu #(
    .W (SUM_W)
  ) u_alu (
    .a_i  (acc_q),
    .b_i  (mem_rdata),
    .op_i (sub_q),
    .y_o  (alu_y)
  );

  // split point and tree neighbors of the current node
  assign mid     = s_q + IDX_W'((e_q - s_q) >> 1);
  assign mid_x   = X_W'(mid);
  assign mid_p1  = mid_x + X_W'(1);
  assign lchild  = (node_q << 1) + NODE_W'(1);
  assign rchild  = (node_q << 1) + NODE_W'(2);
  assign sibling = node_q[0] ? node_q + NODE_W'(1) : node_q - NODE_W'(1);
  assign parent  = (node_q - NODE_W'(1)) >> 1;

  // request decode: wrapped leaf value and range bounds
  assign nv_ext   = segt_pkg::OUT_W'(new_value_i);
  assign nv_wrap  = nv_ext[VALUE_BITS-1:0];
  assign leaf_val = SUM_W'($signed(nv_wrap));
  assign pos_ok   = 32'(position_i) < 32'(ELEMENT_COUNT);
  assign q_ok     = (range_first_i <= range_last_i)
                    && (32'(range_first_i) < 32'(ELEMENT_COUNT));
  assign hi_p1    = 32'(range_last_i) + 32'd1;
  assign xh       = (hi_p1 > 32'(ELEMENT_COUNT)) ? X_W'(ELEMENT_COUNT) : X_W'(hi_p1);

  assign in_ready_o = (state_q == ST_IDLE) && !clr_busy;
  assign accept     = in_valid_i && in_ready_o;
  assign phase_op   = phase_q ? segt_pkg::ALU_SUB : segt_pkg::ALU_ADD;

  // sequencer
  always_comb begin
    state_d     = state_q;
    node_d      = node_q;
    s_d         = s_q;
    e_d         = e_q;
    x_d         = x_q;
    xl_d        = xl_q;
    phase_d     = phase_q;
    pend_d      = 1'b0;
    sub_d       = sub_q;
    acc_d       = pend_q ? alu_y : acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_sum_d   = out_sum_q;
    mem_we      = 1'b0;
    mem_waddr   = node_q;
    mem_wdata   = acc_q;
    mem_raddr   = node_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          node_d = '0;
          s_d    = '0;
          e_d    = IDX_W'(ELEMENT_COUNT - 1);
          if (cmd_i == segt_pkg::CMD_UPDATE) begin
            if (pos_ok) begin
              x_d     = X_W'(position_i);
              acc_d   = leaf_val;
              state_d = ST_UDESC;
            end
          end else begin
            acc_d = '0;
            if (q_ok) begin
              x_d     = xh;
              xl_d    = X_W'(range_first_i);
              phase_d = 1'b0;
              state_d = ST_QSTART;
            end else begin
              state_d = ST_OUT;
            end
          end
        end
      end

      // walk down to the target leaf
      ST_UDESC: begin
        if (s_q == e_q) begin
          mem_we    = 1'b1;
          mem_waddr = node_q;
          mem_wdata = acc_q;
          state_d   = ST_UREAD;
        end else if (x_q <= mid_x) begin
          node_d = lchild;
          e_d    = mid;
        end else begin
          node_d = rchild;
          s_d    = mid + IDX_W'(1);
        end
      end

      // fetch the sibling sum
      ST_UREAD: begin
        mem_raddr = sibling;
        pend_d    = 1'b1;
        sub_d     = segt_pkg::ALU_ADD;
        state_d   = ST_UADD;
      end

      // parent sum = own + sibling
      ST_UADD: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = alu_y;
        node_d    = parent;
        state_d   = (parent == '0) ? ST_IDLE : ST_UREAD;
      end

      // start of one prefix walk
      ST_QSTART: begin
        node_d = '0;
        s_d    = '0;
        e_d    = IDX_W'(ELEMENT_COUNT - 1);
        if (x_q == '0 || x_q == X_W'(ELEMENT_COUNT)) begin
          if (x_q != '0) begin
            mem_raddr = '0;
            pend_d    = 1'b1;
            sub_d     = phase_op;
          end
          if (!phase_q) begin
            phase_d = 1'b1;
            x_d     = xl_q;
          end else begin
            state_d = ST_QDRAIN;
          end
        end else begin
          state_d = ST_QDESC;
        end
      end

      // prefix walk: take whole left children on the way down
      ST_QDESC: begin
        if (x_q > mid_x) begin
          mem_raddr = lchild;
          pend_d    = 1'b1;
          sub_d     = phase_op;
          if (x_q == mid_p1) begin
            if (!phase_q) begin
              phase_d = 1'b1;
              x_d     = xl_q;
              state_d = ST_QSTART;
            end else begin
              state_d = ST_QDRAIN;
            end
          end else begin
            node_d = rchild;
            s_d    = mid + IDX_W'(1);
          end
        end else begin
          node_d = lchild;
          e_d    = mid;
        end
      end

      // last read lands in the accumulator
      ST_QDRAIN: begin
        state_d = ST_OUT;
      end

      // hand the sum to the output register
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_sum_d   = segt_pkg::OUT_W'($signed(acc_q));
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 1'b0;
      pend_q      <= 1'b0;
      sub_q       <= segt_pkg::ALU_ADD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      pend_q      <= pend_d;
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    node_q    <= node_d;
    s_q       <= s_d;
    e_q       <= e_d;
    x_q       <= x_d;
    xl_q      <= xl_d;
    acc_q     <= acc_d;
    out_sum_q <= out_sum_d;
  end

  assign out_valid_o = out_valid_q;
  assign range_sum_o = out_sum_q;

  // parent update always has fresh sibling data to add
  `SEGT_ASSERT(a_uadd_has_data, (state_q == ST_UADD) |-> (pend_q && sub_q == segt_pkg::ALU_ADD))
  // the root is never asked for a sibling
  `SEGT_ASSERT(a_no_root_sibling, (state_q == ST_UREAD) |-> (node_q != '0))
  // a result only appears out of the output state
  `SEGT_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> $past(state_q == ST_OUT))
  // tree writes never collide with the clearing sweep
  `SEGT_ASSERT(a_no_write_in_clear, mem_we |-> !clr_busy)
  // no result is shown right after reset
  `SEGT_ASSERT_NRST(a_reset_quiet, !rst_ni |=> !out_valid_q)

endmodule

/* tb/sv/segment_tree_range_sum_test.sv */
// self-checking testbench for the segment tree range sum block
`timescale 1ns / 100ps

module segment_tree_range_sum_test;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_COUNT  = 1830;
  localparam int DRAIN_EVERY   = 400;
  localparam int SETTLE_CYCLES = 100;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic                              cmd;
    logic        [segt_pkg::POS_W-1:0] position;
    logic signed [segt_pkg::NV_W-1:0]  new_value;
    logic        [segt_pkg::POS_W-1:0] range_first;
    logic        [segt_pkg::POS_W-1:0] range_last;
    bit                                hold;
  } seg_req_t;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              in_valid_i    = 1'b0;
  logic                              in_ready_o;
  logic                              cmd_i         = segt_pkg::CMD_UPDATE;
  logic        [segt_pkg::POS_W-1:0] position_i    = '0;
  logic signed [segt_pkg::NV_W-1:0]  new_value_i   = '0;
  logic        [segt_pkg::POS_W-1:0] range_first_i = '0;
  logic        [segt_pkg::POS_W-1:0] range_last_i  = '0;
  logic                              out_valid_o;
  logic                              out_ready_i   = 1'b0;
  logic signed [segt_pkg::OUT_W-1:0] range_sum_o;

  // shadow copy of the element array and pending work
  logic signed [segt_pkg::NV_W-1:0]  element_vals [segt_pkg::ELEMENT_COUNT_DEF];
  seg_req_t                          pending_reqs [$];
  logic signed [segt_pkg::OUT_W-1:0] expected_sums [$];

  int n_total     = 0;
  int n_sent      = 0;
  int n_taken     = 0;
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct;
  int recv_idle_pct;

  segment_tree_range_sum u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .position_i    (position_i),
    .new_value_i   (new_value_i),
    .range_first_i (range_first_i),
    .range_last_i  (range_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .range_sum_o   (range_sum_o)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // idle rates by progress: sender light first, then receiver light, then none
  assign send_idle_pct = (n_taken < n_total / 3) ? 16 :
                         (n_taken < 2 * n_total / 3) ? 69 : 0;
  assign recv_idle_pct = (n_taken < n_total / 3) ? 69 :
                         (n_taken < 2 * n_total / 3) ? 16 : 0;

  // sum of elements first..last, low bits of the wide total
  function automatic logic signed [segt_pkg::OUT_W-1:0] range_total(int first, int last);
    longint acc;
    acc = 0;
    for (int i = first; i <= last; i++) acc += element_vals[i];
    return acc[segt_pkg::OUT_W-1:0];
  endfunction

  function automatic void queue_update(int pos, logic signed [segt_pkg::NV_W-1:0] val);
    seg_req_t    req;
    int unsigned filler_first;
    int unsigned filler_last;
    filler_first    = $urandom;
    filler_last     = $urandom;
    req.cmd         = segt_pkg::CMD_UPDATE;
    req.position    = pos[segt_pkg::POS_W-1:0];
    req.new_value   = val;
    req.range_first = filler_first[segt_pkg::POS_W-1:0];
    req.range_last  = filler_last[segt_pkg::POS_W-1:0];
    req.hold        = 1'b0;
    pending_reqs.push_back(req);
  endfunction

  function automatic void queue_query(int first, int last);
    seg_req_t    req;
    int unsigned filler_pos;
    filler_pos      = $urandom;
    req.cmd         = segt_pkg::CMD_QUERY;
    req.position    = filler_pos[segt_pkg::POS_W-1:0];
    req.new_value   = $urandom;
    req.range_first = first[segt_pkg::POS_W-1:0];
    req.range_last  = last[segt_pkg::POS_W-1:0];
    req.hold        = 1'b0;
    pending_reqs.push_back(req);
  endfunction

  task automatic note_mismatch(string what, logic signed [segt_pkg::OUT_W-1:0] want,
                               logic signed [segt_pkg::OUT_W-1:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("mismatch (%s): expected %0d, got %0d", what, want, got);
    end
  endtask

  // request driver, changes inputs on the falling edge
  always @(negedge clk_i) begin : drive_requests
    seg_req_t next_req;
    if (rst_ni && n_sent == n_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct &&
          !(pending_reqs[0].hold && expected_sums.size() > 0)) begin
        next_req      = pending_reqs.pop_front();
        cmd_i         <= next_req.cmd;
        position_i    <= next_req.position;
        new_value_i   <= next_req.new_value;
        range_first_i <= next_req.range_first;
        range_last_i  <= next_req.range_last;
        in_valid_i    <= 1'b1;
        n_sent++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // accepted request: update the shadow array or predict the sum
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (cmd_i == segt_pkg::CMD_UPDATE) begin
        element_vals[position_i] = new_value_i;
      end else begin
        expected_sums.push_back(range_total(int'(range_first_i), int'(range_last_i)));
      end
      n_taken++;
    end
  end

  // result checker
  always @(posedge clk_i) begin : check_sums
    logic signed [segt_pkg::OUT_W-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_sums.size() == 0) begin
        note_mismatch("no query pending", '0, range_sum_o);
      end else begin
        want = expected_sums.pop_front();
        if (range_sum_o !== want) note_mismatch("range_sum", want, range_sum_o);
      end
    end
  end

  // run limit
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("segment_tree_range_sum_test: done, errors");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int r;
    int a;
    int b;
    int first;
    int last;
    logic signed [segt_pkg::NV_W-1:0] val;

    foreach (element_vals[i]) element_vals[i] = '0;

    // directed: empty tree, extreme values at both ends, empty ranges,
    // ranges across the root split, overwrites
    queue_query(0, 1023);
    queue_update(0, 32'sh7FFF_FFFF);
    queue_update(1023, 32'sh8000_0000);
    queue_query(0, 0);
    queue_query(1023, 1023);
    queue_query(0, 1023);
    queue_query(1023, 0);
    queue_query(512, 511);
    queue_update(511, -32'sd1);
    queue_update(512, 32'sh7FFF_FFFF);
    queue_query(511, 512);
    queue_update(0, 32'sd0);
    queue_query(0, 511);
    queue_query(512, 1023);
    queue_update(1, 32'sh5555_5555);
    queue_update(1022, 32'shAAAA_AAAA);
    queue_query(1, 1022);
    queue_query(0, 1);
    queue_query(0, 1023);

    // random mix, biased toward extreme values so sums grow wide
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      if ($urandom_range(99) < 50) begin
        r = $urandom_range(99);
        if (r < 25) val = 32'sh7FFF_FFFF;
        else if (r < 40) val = 32'sh8000_0000;
        else val = $urandom;
        r = $urandom_range(99);
        if (r < 10) a = $urandom_range(7);
        else if (r < 20) a = $urandom_range(1023, 1016);
        else a = $urandom_range(1023);
        queue_update(a, val);
      end else begin
        r = $urandom_range(99);
        if (r < 10) begin
          first = $urandom_range(1023, 1);
          last  = $urandom_range(first - 1, 0);
        end else if (r < 20) begin
          first = $urandom_range(1023);
          last  = first;
        end else if (r < 35) begin
          first = $urandom_range(15);
          last  = $urandom_range(1023, 1008);
        end else begin
          a = $urandom_range(1023);
          b = $urandom_range(1023);
          first = (a < b) ? a : b;
          last  = (a < b) ? b : a;
        end
        queue_query(first, last);
      end
      // sender waits for all results at these points
      if (n % DRAIN_EVERY == 0) pending_reqs[$].hold = 1'b1;
    end
    n_total = pending_reqs.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (n_taken == n_total);
    wait (expected_sums.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("segment_tree_range_sum_test: done, clean");
    end else begin
      $display("segment_tree_range_sum_test: done, errors");
    end
    $finish;
  end

endmodule
